/* hw/rtl/itp_pkg.sv */
// shared types, constants and helper functions for the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  // stack geometry and operand masking
  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned OPERAND_BITS = 32;
  localparam int unsigned PTR_W        = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STK_W        = 3;
  localparam int unsigned VALUE_W      = 32;

  // input token kinds
  typedef enum logic [3:0] {
    KIND_OPERAND = 4'd0,
    KIND_ADD     = 4'd1,
    KIND_SUB     = 4'd2,
    KIND_MUL     = 4'd3,
    KIND_DIV     = 4'd4,
    KIND_MOD     = 4'd5,
    KIND_POW     = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_END     = 4'd9,
    KIND_IGNORED = 4'd10
  } kind_e;

  // stack entry and output kind codes
  localparam logic [STK_W-1:0] STK_LPAREN  = 3'd7;
  localparam logic [2:0]       OUT_OPERAND = 3'd0;
  localparam logic [2:0]       OUT_END     = 3'd7;

  // payload structs
  typedef struct packed {
    logic [3:0]         token_kind;
    logic [VALUE_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         out_kind;
    logic [VALUE_W-1:0] out_value;
    logic               overflow;
    logic               last;
  } out_t;

  // operator precedence, a stacked paren and other codes get zero
  function automatic logic [1:0] prec_of(input logic [STK_W-1:0] kind);
    logic [1:0] p;
    unique case (kind)
      3'd1, 3'd2:       p = 2'd1;
      3'd3, 3'd4, 3'd5: p = 2'd2;
      3'd6:             p = 2'd3;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

  // keep only the low OPERAND_BITS of an operand
  function automatic logic [VALUE_W-1:0] operand_mask(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] m;
    for (int i = 0; i < VALUE_W; i++) begin
      m[i] = (i < OPERAND_BITS) ? v[i] : 1'b0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter.sv */
// shunting-yard infix to postfix converter with the operator stack in a ram
// an accepted operand goes through the pending register and then the output register
// each stack entry read goes through ST_READ (ram read), then ST_EVAL (evaluate)
// items with no stack read pass ST_IDLE, ST_READ and ST_FINISH; each entry read adds ST_READ and ST_EVAL
// one item is in work at a time; the output register lets the next item enter early
// reset: async active low, clears stack count, overflow flag and all handshake state
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_EVAL   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         kind_q, kind_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               pend_valid_q, pend_valid_d;
  out_t               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic               wr_en;
  logic [STK_W-1:0]   rd_data;
  logic [CNT_W-1:0]   cnt_m1;
  logic               do_push;
  logic               do_emit;
  out_t               emit_res;
  logic               out_free;
  logic               emit_ok;
  logic               is_op;
  logic [STK_W-1:0]   top;

  // operator stack storage
  itp_ram #(
    .WIDTH (STK_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[PTR_W-1:0]),
    .wdata_i (kind_q[STK_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign rd_addr  = cnt_m1[PTR_W-1:0];
  assign top      = rd_data;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_ok  = !pend_valid_q || out_free;
  assign is_op    = (kind_q >= KIND_ADD) && (kind_q <= KIND_POW);

  // sequencer: emit operands, else read the top entry, evaluate it, pop or push, then flush
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    do_push  = 1'b0;
    do_emit  = 1'b0;
    emit_res = '{out_kind: OUT_OPERAND, out_value: '0, overflow: ovf_q, last: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.token_kind;
          val_d   = in_data_i.operand_value;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        priority if (kind_q == KIND_OPERAND) begin
          if (emit_ok) begin
            do_emit            = 1'b1;
            emit_res.out_value = operand_mask(val_q);
            state_d            = ST_FINISH;
          end
        end else if (kind_q == KIND_LPAREN) begin
          do_push = 1'b1;
          state_d = ST_FINISH;
        end else if (is_op || kind_q == KIND_RPAREN || kind_q == KIND_END) begin
          if (cnt_q != '0) begin
            rd_en   = 1'b1;
            state_d = ST_EVAL;
          end else if (is_op) begin
            do_push = 1'b1;
            state_d = ST_FINISH;
          end else if (kind_q == KIND_END) begin
            if (emit_ok) begin
              do_emit           = 1'b1;
              emit_res.out_kind = OUT_END;
              ovf_d             = 1'b0;
              state_d           = ST_FINISH;
            end
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_EVAL: begin
        priority if (kind_q == KIND_RPAREN) begin
          if (top == STK_LPAREN) begin
            cnt_d   = cnt_m1;
            state_d = ST_FINISH;
          end else if (emit_ok) begin
            do_emit           = 1'b1;
            emit_res.out_kind = top;
            cnt_d             = cnt_m1;
            state_d           = ST_READ;
          end
        end else if (kind_q == KIND_END) begin
          if (top == STK_LPAREN) begin
            cnt_d   = cnt_m1;
            state_d = ST_READ;
          end else if (emit_ok) begin
            do_emit           = 1'b1;
            emit_res.out_kind = top;
            cnt_d             = cnt_m1;
            state_d           = ST_READ;
          end
        end else begin
          if (top != STK_LPAREN && prec_of(top) >= prec_of(kind_q[STK_W-1:0])) begin
            if (emit_ok) begin
              do_emit           = 1'b1;
              emit_res.out_kind = top;
              cnt_d             = cnt_m1;
              state_d           = ST_READ;
            end
          end else begin
            do_push = 1'b1;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // push onto the stack, a full stack drops the token and sets the flag
    if (do_push) begin
      if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
        ovf_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // pending result holds back one result so the final one can carry last
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    if (do_emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
      end
      pend_valid_d = 1'b1;
      pend_d       = emit_res;
    end else if (state_q == ST_FINISH && pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/itp_ram.sv */
// generic single write, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
